FILE: rtl/qla_pkg.sv
`timescale 1ns / 1ps

package qla_pkg;

  // Sequencer states of the agent.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_OLD,
    ST_MUL_G,
    ST_T,
    ST_MUL_A,
    ST_WRITE,
    ST_DONE
  } state_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LEARN_RATE   = 3'd0,
    REG_DISCOUNT     = 3'd1,
    REG_EXPLORE_PROB = 3'd2,
    REG_NUM_LEVELS   = 3'd3,
    REG_Q_INITIAL    = 3'd4,
    REG_ANGLE_MAX    = 3'd5,
    REG_ANGLE_STEP   = 3'd6
  } reg_index_t;

  // Action codes.
  localparam logic [1:0] ACT_LOWER = 2'd0;
  localparam logic [1:0] ACT_STAY  = 2'd1;
  localparam logic [1:0] ACT_RAISE = 2'd2;

  // Field widths.
  localparam int DIST_W       = 32;
  localparam int RAND_W       = 16;
  localparam int COEF_W       = 17;
  localparam int NUM_LEVELS_W = 7;
  localparam int QINIT_W      = 32;
  localparam int ANGLE_MAX_W  = 18;
  localparam int ANGLE_STEP_W = 19;
  localparam int ANGLE_W      = 19;
  localparam int REWARD_W     = 32;
  localparam int LEVEL_OUT_W  = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 64;

  // Bounds on three times the action random (thirds), and on the random itself (half).
  localparam logic [RAND_W+1:0] RAND_HALF       = 18'd32768;
  localparam logic [RAND_W+1:0] RAND_THIRD      = 18'd65536;
  localparam logic [RAND_W+1:0] RAND_TWO_THIRDS = 18'd131072;

  // Round half up before dropping the sixteen fraction bits.
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_BIAS = 32768;

endpackage

FILE: rtl/q_learning_level_agent_top.sv
`timescale 1ns / 1ps

// Epsilon-greedy tabular Q-learning agent that steps a target angle between
// discrete levels. Each input beat carries a distance and two random values;
// each one yields exactly one output beat with the new target angle, the
// reward, the chosen action and the level reached. The Q table sits in one
// row-wide memory (three actions per level, each entry with a written flag),
// so the new level's row and the old level's row are read one after the other
// through its single read port, followed by two multiplications in turn. The
// initialising first beat skips the row reads. After reset a clearing pass
// marks every entry unwritten; no beat is accepted during it, while
// configuration writes are taken at all times.
module q_learning_level_agent_top #(
  parameter int MAX_LEVELS = 64,
  parameter int Q_WIDTH    = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [qla_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [qla_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // distance [31:0], rand_action [47:32], rand_explore [63:48]
  input  logic [qla_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // target_angle [18:0], reward_value [50:19], chosen_action [52:51],
  // level_now [58:53], explored [59], zeros [63:60]
  output logic [qla_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // first_event [0]
  output logic                               m_axis_tuser
);

  import qla_pkg::*;

  localparam int LW = $clog2(MAX_LEVELS);
  localparam int CW = (LW + 1 > NUM_LEVELS_W) ? LW + 1 : NUM_LEVELS_W;
  localparam int EW = Q_WIDTH + 1;
  localparam int RW = 3 * EW;
  localparam int VW = (Q_WIDTH > QINIT_W) ? Q_WIDTH : QINIT_W;
  localparam int TW = VW + 5;
  localparam int AW = LW + 21;

  // Configuration registers.
  logic [COEF_W-1:0]       learn_rate;
  logic [COEF_W-1:0]       discount;
  logic [COEF_W-1:0]       explore_prob;
  logic [NUM_LEVELS_W-1:0] num_levels;
  logic [QINIT_W-1:0]      q_initial;
  logic [ANGLE_MAX_W-1:0]  angle_max;
  logic [ANGLE_STEP_W-1:0] angle_step;

  // Agent state and sequencer.
  state_t            state;
  state_t            state_next;
  logic [LW-1:0]     clr_addr;
  logic              started;
  logic [DIST_W-1:0] prev_distance;
  logic [LW-1:0]     current_level;
  logic [1:0]        last_action;

  // Per-beat working registers.
  logic [LW-1:0]              old_lvl;
  logic [1:0]                 old_act;
  logic [RAND_W-1:0]          rand_action_r;
  logic [RAND_W-1:0]          rand_explore_r;
  logic signed [REWARD_W-1:0] reward_r;
  logic                       first_r;
  logic signed [VW-1:0]       qmax_r;
  logic [1:0]                 act_r;
  logic                       explored_r;
  logic [LW-1:0]              tgt_r;
  logic signed [VW-1:0]       qold_r;
  logic [RW-1:0]              row_r;
  logic signed [VW+17:0]      prod1_r;
  logic signed [TW-1:0]       t_r;
  logic signed [TW+17:0]      prod2_r;
  logic [LW+18:0]             ang_prod_r;

  // Memory port signals.
  logic          ram_we;
  logic [LW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [LW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  // Combinational helpers.
  logic [DIST_W-1:0]     in_distance;
  logic [RAND_W-1:0]     in_rand_action;
  logic [RAND_W-1:0]     in_rand_explore;
  logic [CW-1:0]         nl_wide;
  logic [LW:0]           nl;
  logic [LW:0]           nl_m1;
  logic signed [LW+2:0]  nl_m1_s;
  logic signed [LW+2:0]  lv_s;
  logic [LW-1:0]         level_calc;
  logic [DIST_W:0]       dist_diff;
  logic signed [REWARD_W-1:0] reward_calc;
  logic accept;
  logic out_free;

  logic signed [VW-1:0] q_init_ext;
  logic signed [VW-1:0] row_q [3];
  logic signed [VW-1:0] qmax_calc;
  logic signed [VW-1:0] qold_calc;
  logic signed [VW-1:0] m01;
  logic [1:0]           best01;
  logic [1:0]           best;
  logic [1:0]           rnd_act;
  logic [RAND_W+1:0]    r3;
  logic                 at_bottom;
  logic                 at_top;
  logic                 explore;
  logic [1:0]           act_calc;
  logic signed [LW+2:0] tgt_s;
  logic [LW-1:0]        tgt_calc;

  logic signed [VW+18:0] sum1;
  logic signed [VW+2:0]  r1;
  logic signed [TW-1:0]  t_next;
  logic signed [TW+18:0] sum2;
  logic signed [TW+2:0]  r2;
  logic signed [TW+3:0]  qnew;
  logic [TW+4-Q_WIDTH:0] q_upper;
  logic [Q_WIDTH-1:0]    qsat;
  logic [RW-1:0]         wr_row;

  logic signed [AW-1:0]  ang_s;
  logic [AW-19:0]        ang_upper;
  logic [ANGLE_W-1:0]    ang_sat;
  logic [LW+5:0]         lvl_ext;

  assign in_distance     = s_axis_tdata[31:0];
  assign in_rand_action  = s_axis_tdata[47:32];
  assign in_rand_explore = s_axis_tdata[63:48];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate   <= '0;
      discount     <= '0;
      explore_prob <= '0;
      num_levels   <= NUM_LEVELS_W'(3);
      q_initial    <= '0;
      angle_max    <= '0;
      angle_step   <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_addr))
        REG_LEARN_RATE:   learn_rate   <= cfg_wdata[COEF_W-1:0];
        REG_DISCOUNT:     discount     <= cfg_wdata[COEF_W-1:0];
        REG_EXPLORE_PROB: explore_prob <= cfg_wdata[COEF_W-1:0];
        REG_NUM_LEVELS:   num_levels   <= cfg_wdata[NUM_LEVELS_W-1:0];
        REG_Q_INITIAL:    q_initial    <= cfg_wdata[QINIT_W-1:0];
        REG_ANGLE_MAX:    angle_max    <= cfg_wdata[ANGLE_MAX_W-1:0];
        REG_ANGLE_STEP:   angle_step   <= cfg_wdata[ANGLE_STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Number of levels in use, held to the range two to MAX_LEVELS.
  always_comb begin
    nl_wide = CW'(num_levels);
    if (nl_wide < CW'(2)) begin
      nl_wide = CW'(2);
    end else if (nl_wide > CW'(MAX_LEVELS)) begin
      nl_wide = CW'(MAX_LEVELS);
    end
    nl      = nl_wide[LW:0];
    nl_m1   = nl - (LW+1)'(1);
    nl_m1_s = $signed({2'b00, nl_m1});
  end

  // Level reached by the last action, and the reward of this beat.
  always_comb begin
    lv_s = $signed({3'b000, current_level}) + $signed((LW+3)'(last_action))
           - $signed((LW+3)'(1));
    if (!started) begin
      level_calc = nl[LW:1];
    end else if (lv_s < 0) begin
      level_calc = '0;
    end else if (lv_s > nl_m1_s) begin
      level_calc = nl_m1[LW-1:0];
    end else begin
      level_calc = lv_s[LW-1:0];
    end
    dist_diff = {1'b0, prev_distance} - {1'b0, in_distance};
    if (dist_diff[DIST_W] != dist_diff[DIST_W-1]) begin
      reward_calc = dist_diff[DIST_W] ? {1'b1, {(REWARD_W-1){1'b0}}}
                                      : {1'b0, {(REWARD_W-1){1'b1}}};
    end else begin
      reward_calc = dist_diff[REWARD_W-1:0];
    end
  end

  // Entries of the row just read; an unwritten entry reads as the initial value.
  always_comb begin
    q_init_ext = VW'($signed(q_initial));
    for (int a = 0; a < 3; a++) begin
      row_q[a] = ram_rdata[a*EW + Q_WIDTH] ? VW'($signed(ram_rdata[a*EW +: Q_WIDTH]))
                                            : q_init_ext;
    end
    case (old_act)
      ACT_LOWER: qold_calc = row_q[0];
      ACT_STAY:  qold_calc = row_q[1];
      default:   qold_calc = row_q[2];
    endcase
  end

  // Greedy and random choice at the new level.
  always_comb begin
    at_bottom = (current_level == '0);
    at_top    = ({1'b0, current_level} == nl_m1);
    r3        = {2'b00, rand_action_r} + {1'b0, rand_action_r, 1'b0};
    m01       = (row_q[1] > row_q[0]) ? row_q[1] : row_q[0];
    best01    = (row_q[1] > row_q[0]) ? ACT_STAY : ACT_LOWER;
    if (at_bottom) begin
      best      = (row_q[2] > row_q[1]) ? ACT_RAISE : ACT_STAY;
      qmax_calc = (row_q[2] > row_q[1]) ? row_q[2] : row_q[1];
      rnd_act   = ({2'b00, rand_action_r} < RAND_HALF) ? ACT_STAY : ACT_RAISE;
    end else if (at_top) begin
      best      = best01;
      qmax_calc = m01;
      rnd_act   = ({2'b00, rand_action_r} < RAND_HALF) ? ACT_LOWER : ACT_STAY;
    end else begin
      best      = (row_q[2] > m01) ? ACT_RAISE : best01;
      qmax_calc = (row_q[2] > m01) ? row_q[2] : m01;
      if (r3 < RAND_THIRD) begin
        rnd_act = ACT_LOWER;
      end else if (r3 < RAND_TWO_THIRDS) begin
        rnd_act = ACT_STAY;
      end else begin
        rnd_act = ACT_RAISE;
      end
    end
    explore  = ({1'b0, rand_explore_r} <= explore_prob);
    act_calc = explore ? rnd_act : best;
    tgt_s    = $signed({3'b000, current_level}) + $signed((LW+3)'(act_calc))
               - $signed((LW+3)'(1));
    if (tgt_s < 0) begin
      tgt_calc = '0;
    end else if (tgt_s > nl_m1_s) begin
      tgt_calc = nl_m1[LW-1:0];
    end else begin
      tgt_calc = tgt_s[LW-1:0];
    end
  end

  // Temporal difference and the saturated new Q value.
  always_comb begin
    sum1   = (VW+19)'(prod1_r) + (VW+19)'(ROUND_BIAS);
    r1     = sum1[VW+18:FRAC_BITS];
    t_next = TW'(reward_r) + TW'(r1) - TW'(qold_r);
    sum2   = (TW+19)'(prod2_r) + (TW+19)'(ROUND_BIAS);
    r2     = sum2[TW+18:FRAC_BITS];
    qnew   = (TW+4)'(qold_r) + (TW+4)'(r2);
    q_upper = qnew[TW+3:Q_WIDTH-1];
    if ((&q_upper) || !(|q_upper)) begin
      qsat = qnew[Q_WIDTH-1:0];
    end else begin
      qsat = qnew[TW+3] ? {1'b1, {(Q_WIDTH-1){1'b0}}} : {1'b0, {(Q_WIDTH-1){1'b1}}};
    end
    wr_row = row_r;
    case (old_act)
      ACT_LOWER: wr_row[0 +: EW]    = {1'b1, qsat};
      ACT_STAY:  wr_row[EW +: EW]   = {1'b1, qsat};
      default:   wr_row[2*EW +: EW] = {1'b1, qsat};
    endcase
  end

  // Target angle, saturated to the output range.
  always_comb begin
    ang_s     = $signed({2'b00, ang_prod_r}) - $signed(AW'(angle_max));
    ang_upper = ang_s[AW-1:ANGLE_W-1];
    if ((&ang_upper) || !(|ang_upper)) begin
      ang_sat = ang_s[ANGLE_W-1:0];
    end else begin
      ang_sat = ang_s[AW-1] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
    end
    lvl_ext = {6'b000000, current_level};
  end

  // Next state, handshake and memory control.
  always_comb begin
    state_next    = state;
    s_axis_tready = (state == ST_IDLE);
    accept        = s_axis_tvalid && (state == ST_IDLE);
    out_free      = !m_axis_tvalid || m_axis_tready;
    ram_we        = 1'b0;
    ram_waddr     = old_lvl;
    ram_wdata     = wr_row;
    ram_raddr     = (state == ST_IDLE) ? level_calc : old_lvl;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == LW'(MAX_LEVELS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = started ? ST_READ_OLD : ST_T;
        end
      end
      ST_READ_OLD: state_next = ST_MUL_G;
      ST_MUL_G:    state_next = ST_T;
      ST_T:        state_next = ST_MUL_A;
      ST_MUL_A:    state_next = ST_WRITE;
      ST_WRITE: begin
        ram_we     = !first_r;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register and agent state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      started       <= 1'b0;
      prev_distance <= '0;
      current_level <= '0;
      last_action   <= ACT_STAY;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + LW'(1);
      end
      if (accept) begin
        started       <= 1'b1;
        prev_distance <= in_distance;
        current_level <= level_calc;
        if (!started) begin
          last_action <= ACT_STAY;
        end
      end
      if (state == ST_READ_OLD) begin
        last_action <= act_calc;
      end
    end
  end

  // Working registers of one beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      old_lvl        <= current_level;
      old_act        <= last_action;
      rand_action_r  <= in_rand_action;
      rand_explore_r <= in_rand_explore;
      first_r        <= !started;
      reward_r       <= started ? reward_calc : '0;
      if (!started) begin
        act_r      <= ACT_STAY;
        explored_r <= 1'b0;
        tgt_r      <= level_calc;
      end
    end
    if (state == ST_READ_OLD) begin
      qmax_r     <= qmax_calc;
      act_r      <= act_calc;
      explored_r <= explore;
      tgt_r      <= tgt_calc;
    end
    if (state == ST_MUL_G) begin
      qold_r  <= qold_calc;
      row_r   <= ram_rdata;
      prod1_r <= $signed({1'b0, discount}) * qmax_r;
    end
    if (state == ST_T) begin
      t_r        <= t_next;
      ang_prod_r <= tgt_r * angle_step;
    end
    if (state == ST_MUL_A) begin
      prod2_r <= $signed({1'b0, learn_rate}) * t_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_axis_tdata <= {4'b0000, explored_r, lvl_ext[LEVEL_OUT_W-1:0], act_r,
                       reward_r, ang_sat};
      m_axis_tuser <= first_r;
    end
  end

  qla_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_LEVELS)
  ) u_q_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  // A finished result is always presented once the output slot is free.
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (m_axis_tvalid && state == ST_IDLE))
    else $error("result not presented after completion");

  // The chosen action is always lower, stay or raise.
  a_action_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[52:51] != 2'd3))
    else $error("invalid action code on output");

  // The initialising beat carries no reward and keeps the level.
  a_first_beat: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[50:19] == 32'd0 && m_axis_tdata[52:51] == ACT_STAY &&
       !m_axis_tdata[59]))
    else $error("first beat with reward, move or exploration");

  // Once started the agent never returns to its initial state.
  a_started_holds: assert property (@(posedge clk) disable iff (rst)
    !$fell(started))
    else $error("started flag cleared outside reset");

  // The Q memory is never written while a beat is waiting for its rows.
  a_no_early_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ_OLD || state == ST_MUL_G) |-> !ram_we)
    else $error("Q memory written during row reads");
`endif

endmodule

FILE: rtl/qla_ram.sv
`timescale 1ns / 1ps

module qla_ram #(
  parameter int WIDTH = 99,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
